### rtl/core/sled_pkg.sv
// Types, codes and defaults shared by the status LED blink controller.
package sled_pkg;

  localparam int unsigned TimerBitsDefault = 16;
  localparam int unsigned RegW             = 16;
  localparam int unsigned CfgIdxW          = 2;

  localparam logic [RegW-1:0] ConnectingBlinkRst = 16'd500;
  localparam logic [RegW-1:0] StreamingBlinkRst  = 16'd100;
  localparam logic [RegW-1:0] ErrorBlinkRst      = 16'd50;
  localparam logic [RegW-1:0] ConnectedHoldRst   = 16'd5000;

  typedef enum logic [2:0] {
    ModeOff        = 3'd0,
    ModeConnecting = 3'd1,
    ModeConnected  = 3'd2,
    ModeStreaming  = 3'd3,
    ModeError      = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    ActTick    = 2'd0,
    ActStream  = 2'd1,
    ActSetMode = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    LinkConnected = 2'd0,
    LinkIdle      = 2'd1,
    LinkDown      = 2'd2
  } link_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgConnectingBlink = 2'd0,
    CfgStreamingBlink  = 2'd1,
    CfgErrorBlink      = 2'd2,
    CfgConnectedHold   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0] action;
    logic [1:0] link_status;
    logic       streaming_on;
    logic [2:0] new_mode;
  } in_t;

  typedef struct packed {
    logic       led_on;
    logic [2:0] current_mode;
  } out_t;

  typedef struct packed {
    logic [RegW-1:0] connecting_blink_ms;
    logic [RegW-1:0] streaming_blink_ms;
    logic [RegW-1:0] error_blink_ms;
    logic [RegW-1:0] connected_hold_ms;
  } cfg_t;

  typedef struct packed {
    mode_e mode;
    logic  lit;
    logic  stream_flag;
  } state_t;

endpackage

### rtl/core/sled_next.sv
// Next-state logic of the LED mode machine for one input beat.
module sled_next #(
  parameter int unsigned TIMER_BITS = sled_pkg::TimerBitsDefault
) (
  input  sled_pkg::in_t           in_i,
  input  sled_pkg::cfg_t          cfg_i,
  input  sled_pkg::state_t        state_i,
  input  logic [TIMER_BITS-1:0]   elapsed_i,
  output sled_pkg::state_t        state_o,
  output logic [TIMER_BITS-1:0]   elapsed_o
);
  import sled_pkg::*;

  localparam int unsigned CmpW = (TIMER_BITS > RegW) ? TIMER_BITS : RegW;

  mode_e                 mode;
  mode_e                 tgt;
  logic                  lit;
  logic                  flag;
  logic [TIMER_BITS-1:0] el;
  logic [RegW-1:0]       ival;
  logic                  expired;

  always_comb begin
    mode    = state_i.mode;
    lit     = state_i.lit;
    flag    = state_i.stream_flag;
    el      = elapsed_i;
    tgt     = state_i.mode;
    ival    = '0;
    expired = 1'b0;

    case (in_i.action)
      ActTick: begin
        if (el != {TIMER_BITS{1'b1}}) begin
          el = el + 1'b1;
        end
        case (in_i.link_status)
          LinkConnected: begin
            if (mode == ModeConnecting) begin
              tgt = ModeConnected;
            end
          end
          LinkIdle: begin
            if (mode != ModeStreaming && mode != ModeConnected) begin
              tgt = ModeConnecting;
            end
          end
          LinkDown: begin
            if (!flag) begin
              tgt = ModeOff;
            end
          end
          default: ;
        endcase
        if (tgt != mode) begin
          mode = tgt;
          el   = '0;
          if (tgt == ModeConnected) begin
            lit = 1'b1;
          end else if (tgt == ModeOff) begin
            lit = 1'b0;
          end
        end

        case (mode)
          ModeConnecting: ival = cfg_i.connecting_blink_ms;
          ModeConnected:  ival = cfg_i.connected_hold_ms;
          ModeStreaming:  ival = cfg_i.streaming_blink_ms;
          ModeError:      ival = cfg_i.error_blink_ms;
          default:        ival = '0;
        endcase
        expired = CmpW'(el) >= CmpW'(ival);

        case (mode)
          ModeOff: lit = 1'b0;
          ModeConnected: begin
            if (expired) begin
              mode = ModeOff;
              el   = '0;
              lit  = 1'b0;
            end else begin
              lit = 1'b1;
            end
          end
          ModeConnecting, ModeStreaming, ModeError: begin
            if (expired) begin
              lit = ~lit;
              el  = '0;
            end
          end
          default: ;
        endcase
        tgt = mode;
      end
      ActStream: begin
        flag = in_i.streaming_on;
        if (in_i.streaming_on) begin
          tgt = ModeStreaming;
        end else if (in_i.link_status == LinkConnected) begin
          tgt = ModeOff;
        end
      end
      ActSetMode: begin
        if (in_i.new_mode <= ModeError) begin
          tgt = mode_e'(in_i.new_mode);
        end
      end
      default: ;
    endcase

    if (tgt != mode) begin
      mode = tgt;
      el   = '0;
      if (tgt == ModeConnected) begin
        lit = 1'b1;
      end else if (tgt == ModeOff) begin
        lit = 1'b0;
      end
    end

    state_o.mode        = mode;
    state_o.lit         = lit;
    state_o.stream_flag = flag;
    elapsed_o           = el;
  end

endmodule

### rtl/core/status_led_blink_controller.sv
// Top level of the status LED blink controller: registers, handshake and checks.
//
//   Channel | Direction | Handshake             | Beat
//   --------+-----------+-----------------------+--------------------------
//   in      | input     | in_valid_i/in_stall_o | action, link, flag, mode
//   out     | output    | out_valid_o/out_stall_i | led_on, current_mode
//   cfg     | input     | cfg_we_i              | index and 16-bit value
//
// An accepted beat has its result in the output register on the next edge, so
// beats flow one per cycle while the output side does not stall. The state
// registers and the single output register set this figure. Input stalls
// only while a result is held and the output side stalls. Reset empties the
// output register and loads the default intervals.
module status_led_blink_controller #(
  parameter int unsigned TIMER_BITS = sled_pkg::TimerBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  sled_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output sled_pkg::out_t                out_data_o,
  input  logic                          cfg_we_i,
  input  logic [sled_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sled_pkg::RegW-1:0]     cfg_data_i
);
  import sled_pkg::*;

  cfg_t                  cfg_q;
  state_t                state_q, state_d;
  logic [TIMER_BITS-1:0] elapsed_q, elapsed_d;
  logic                  out_valid_q;
  out_t                  out_q;
  logic                  in_fire;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_fire    = in_valid_i && !in_stall_o;

  sled_next #(
    .TIMER_BITS(TIMER_BITS)
  ) u_next (
    .in_i      (in_data_i),
    .cfg_i     (cfg_q),
    .state_i   (state_q),
    .elapsed_i (elapsed_q),
    .state_o   (state_d),
    .elapsed_o (elapsed_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.connecting_blink_ms <= ConnectingBlinkRst;
      cfg_q.streaming_blink_ms  <= StreamingBlinkRst;
      cfg_q.error_blink_ms      <= ErrorBlinkRst;
      cfg_q.connected_hold_ms   <= ConnectedHoldRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgConnectingBlink: cfg_q.connecting_blink_ms <= cfg_data_i;
        CfgStreamingBlink:  cfg_q.streaming_blink_ms  <= cfg_data_i;
        CfgErrorBlink:      cfg_q.error_blink_ms      <= cfg_data_i;
        CfgConnectedHold:   cfg_q.connected_hold_ms   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode        <= ModeOff;
      state_q.lit         <= 1'b0;
      state_q.stream_flag <= 1'b0;
      elapsed_q           <= '0;
      out_valid_q         <= 1'b0;
    end else begin
      if (in_fire) begin
        state_q   <= state_d;
        elapsed_q <= elapsed_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q.led_on       <= state_d.lit;
      out_q.current_mode <= state_d.mode;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_o)
    else $error("accepted beat produced no result");

  a_connected_lit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.mode == ModeConnected |-> state_q.lit)
    else $error("connected mode with dark LED");

  a_off_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.current_mode == ModeOff |-> !out_data_o.led_on)
    else $error("off mode reported with lit LED");

  a_result_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_data_o.current_mode == state_q.mode && out_data_o.led_on == state_q.lit)
    else $error("result differs from stored state");
`endif

endmodule

### verif/tb_status_led_blink_controller.sv
// Self-checking testbench for the status LED blink controller.
module tb_status_led_blink_controller;
  timeunit 1ns;
  timeprecision 1ps;

  import sled_pkg::*;

  localparam int unsigned TimerW   = TimerBitsDefault;
  localparam logic [1:0]  LinkOther = 2'd3;
  localparam logic [1:0]  ActUnused = 2'd3;
  localparam int unsigned Limit    = 300000;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_t                 in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_t                out_data_o;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [RegW-1:0]     cfg_data_i  = '0;

  status_led_blink_controller dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_data_i,
    .out_valid_o,
    .out_stall_i,
    .out_data_o,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i
  );

  always #10 clk_i = ~clk_i;

  // Predicted controller state and register copy.
  mode_e             mode_q    = ModeOff;
  logic              lit_q     = 1'b0;
  logic              stream_q  = 1'b0;
  logic [TimerW-1:0] elapsed_q = '0;
  cfg_t              regs_q    = '{ConnectingBlinkRst, StreamingBlinkRst,
                                   ErrorBlinkRst, ConnectedHoldRst};

  out_t        led_queue[$];
  int unsigned errors       = 0;
  int unsigned beats        = 0;
  int unsigned settings     = 1;
  int unsigned cycles       = 0;
  int unsigned idle_pct     = 0;
  int unsigned stall_pct    = 0;

  function automatic void switch_mode(mode_e m);
    if (mode_q != m) begin
      mode_q    = m;
      elapsed_q = '0;
      if (m == ModeConnected) begin
        lit_q = 1'b1;
      end else if (m == ModeOff) begin
        lit_q = 1'b0;
      end
    end
  endfunction

  function automatic void blink_step(logic [RegW-1:0] period);
    if (elapsed_q >= period) begin
      lit_q     = ~lit_q;
      elapsed_q = '0;
    end
  endfunction

  function automatic out_t led_next(in_t b);
    out_t r;
    case (b.action)
      ActTick: begin
        if (elapsed_q != '1) begin
          elapsed_q = elapsed_q + 1'b1;
        end
        case (b.link_status)
          LinkConnected: begin
            if (mode_q == ModeConnecting) switch_mode(ModeConnected);
          end
          LinkIdle: begin
            if (mode_q != ModeStreaming && mode_q != ModeConnected) begin
              switch_mode(ModeConnecting);
            end
          end
          LinkDown: begin
            if (!stream_q) switch_mode(ModeOff);
          end
          default: ;
        endcase
        case (mode_q)
          ModeOff:        lit_q = 1'b0;
          ModeConnecting: blink_step(regs_q.connecting_blink_ms);
          ModeStreaming:  blink_step(regs_q.streaming_blink_ms);
          ModeError:      blink_step(regs_q.error_blink_ms);
          ModeConnected: begin
            if (elapsed_q >= regs_q.connected_hold_ms) begin
              switch_mode(ModeOff);
            end else begin
              lit_q = 1'b1;
            end
          end
          default: ;
        endcase
      end
      ActStream: begin
        stream_q = b.streaming_on;
        if (b.streaming_on) begin
          switch_mode(ModeStreaming);
        end else if (b.link_status == LinkConnected) begin
          switch_mode(ModeOff);
        end
      end
      ActSetMode: begin
        if (b.new_mode <= ModeError) switch_mode(mode_e'(b.new_mode));
      end
      default: ;
    endcase
    r.led_on       = lit_q;
    r.current_mode = mode_q;
    return r;
  endfunction

  function automatic in_t beat_of(logic [1:0] act, logic [1:0] link, logic [2:0] m);
    in_t b;
    b.action       = act;
    b.link_status  = link;
    b.streaming_on = 1'($urandom);
    b.new_mode     = m;
    return b;
  endfunction

  task automatic send_beat(in_t b);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    led_queue.push_back(led_next(b));
    beats++;
  endtask

  task automatic send_ticks(int unsigned n, logic [1:0] link);
    repeat (n) send_beat(beat_of(ActTick, link, 3'($urandom)));
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (led_queue.size() != 0) @(posedge clk_i);
  endtask

  task automatic load_regs(logic [RegW-1:0] con, logic [RegW-1:0] str,
                           logic [RegW-1:0] err, logic [RegW-1:0] hold);
    logic [RegW-1:0] vals[4];
    vals = '{con, str, err, hold};
    wait_idle();
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CfgIdxW'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      case (cfg_idx_e'(i))
        CfgConnectingBlink: regs_q.connecting_blink_ms = vals[i];
        CfgStreamingBlink:  regs_q.streaming_blink_ms  = vals[i];
        CfgErrorBlink:      regs_q.error_blink_ms      = vals[i];
        CfgConnectedHold:   regs_q.connected_hold_ms   = vals[i];
        default: ;
      endcase
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    settings++;
  endtask

  function automatic logic [RegW-1:0] pick_period();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 14) return '1;
    if (r < 20) return RegW'(1);
    if (r < 30) return RegW'($urandom);
    if (r < 40) return RegW'($urandom_range(200, 13));
    return RegW'($urandom_range(12, 1));
  endfunction

  function automatic in_t random_beat();
    in_t b;
    int unsigned r;
    b = in_t'(8'($urandom));
    r = $urandom_range(99);
    if (r < 65) begin
      b.action = ActTick;
    end else if (r < 79) begin
      b.action = ActStream;
    end else if (r < 94) begin
      b.action = ActSetMode;
      if ($urandom_range(9) != 0) b.new_mode = 3'($urandom_range(ModeError));
    end else begin
      b.action = ActUnused;
    end
    return b;
  endfunction

  task automatic test_directed();
    send_beat(beat_of(ActTick, LinkOther, 3'd0));
    send_beat(in_t'(8'hFF));
    send_beat(beat_of(ActTick, LinkDown, 3'd0));
    send_beat(beat_of(ActTick, LinkIdle, 3'd0));
    send_beat(beat_of(ActTick, LinkConnected, 3'd0));
    send_beat(beat_of(ActTick, LinkIdle, 3'd0));
    send_beat(beat_of(ActSetMode, LinkOther, 3'd7));
    send_beat(beat_of(ActSetMode, LinkOther, 3'd5));
    send_beat(beat_of(ActSetMode, LinkOther, ModeConnected));
    send_beat('{ActStream, LinkOther, 1'b1, 3'd0});
    send_beat(beat_of(ActTick, LinkIdle, 3'd0));
    send_beat(beat_of(ActTick, LinkDown, 3'd0));
    send_beat('{ActStream, LinkOther, 1'b0, 3'd0});
    send_beat('{ActStream, LinkConnected, 1'b0, 3'd0});
    send_beat(beat_of(ActSetMode, LinkConnected, ModeError));
    send_beat(beat_of(ActTick, LinkDown, 3'd0));
    send_beat(beat_of(ActSetMode, LinkDown, ModeStreaming));
    send_beat(beat_of(ActTick, LinkConnected, 3'd0));
    send_beat(beat_of(ActSetMode, LinkIdle, ModeOff));
    send_beat(beat_of(ActSetMode, LinkIdle, ModeConnecting));
    send_beat(beat_of(ActTick, LinkConnected, 3'd0));
    send_beat('{ActStream, LinkConnected, 1'b1, 3'd6});
    send_beat(beat_of(ActSetMode, LinkOther, 3'd6));
    send_beat(in_t'(8'hC0));
  endtask

  task automatic test_default_periods();
    send_beat(beat_of(ActSetMode, LinkOther, ModeError));
    send_ticks(60, LinkOther);
    send_beat(beat_of(ActSetMode, LinkOther, ModeStreaming));
    send_ticks(110, LinkOther);
    send_beat(beat_of(ActSetMode, LinkOther, ModeConnecting));
    send_ticks(510, LinkOther);
    send_beat(beat_of(ActSetMode, LinkOther, ModeConnected));
    send_ticks(20, LinkOther);
  endtask

  task automatic test_period_extremes();
    logic [RegW-1:0] ends[3];
    ends = '{'0, RegW'(1), '1};
    foreach (ends[k]) begin
      load_regs(ends[k], ends[k], ends[k], ends[k]);
      for (int m = ModeConnecting; m <= ModeError; m++) begin
        send_beat(beat_of(ActSetMode, LinkOther, 3'(m)));
        send_ticks(6, LinkOther);
      end
    end
  endtask

  task automatic test_random_traffic();
    int unsigned mix[4][2];
    mix = '{'{0, 0}, '{50, 0}, '{0, 50}, '{25, 25}};
    foreach (mix[p]) begin
      for (int s = 0; s < 4; s++) begin
        load_regs(pick_period(), pick_period(), pick_period(), pick_period());
        idle_pct  = mix[p][0];
        stall_pct = mix[p][1];
        for (int n = 0; n < 30; n++) begin
          if ($urandom_range(99) == 0) wait_idle();
          send_beat(random_beat());
        end
      end
    end
    idle_pct  = 0;
    stall_pct = 0;
  endtask

  always @(posedge clk_i) begin
    if (stall_pct != 0) begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (led_queue.size() == 0) begin
        $display("%0t: unexpected beat, actual led_on=%0d mode=%0d", $time,
                 out_data_o.led_on, out_data_o.current_mode);
        errors++;
      end else begin
        want = led_queue.pop_front();
        if (out_data_o.led_on !== want.led_on) begin
          $display("%0t: led_on expected %0d actual %0d", $time, want.led_on,
                   out_data_o.led_on);
          errors++;
        end
        if (out_data_o.current_mode !== want.current_mode) begin
          $display("%0t: current_mode expected %0d actual %0d", $time,
                   want.current_mode, out_data_o.current_mode);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= Limit) begin
      $display("%0t: timeout with %0d beats still expected", $time, led_queue.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_default_periods();
    test_period_extremes();
    test_random_traffic();
    wait_idle();
    repeat (5) @(posedge clk_i);
    $display("Checked %0d beats across %0d register settings and four idle/stall mixes.",
             beats, settings);
    if (errors == 0 && led_queue.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/sled_pkg.sv
rtl/core/sled_next.sv
rtl/core/status_led_blink_controller.sv
verif/tb_status_led_blink_controller.sv
